[rtl/round_robin_task_table_assert.svh]
// Assertion macros for the round-robin task table.
`ifndef ROUND_ROBIN_TASK_TABLE_ASSERT_SVH
`define ROUND_ROBIN_TASK_TABLE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define RRTT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define RRTT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/rrtt_pkg.sv]
// Shared constants, command codes and control structs of the task table.
`timescale 1ns / 1ps
package rrtt_pkg;

  localparam int SLOTS      = 8;
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int ID_W       = 31;
  localparam int CMD_W      = 3;
  localparam int RSLOT_W    = 3;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;

  localparam logic [ID_W-1:0] ID_MAX = {ID_W{1'b1}};

  localparam logic [CMD_W-1:0] CMD_CREATE   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SCHEDULE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_EXIT     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_FIND     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DISPATCH = 3'd4;

  // controller to datapath
  typedef struct packed {
    logic ready;   // input side may take an item
    logic load;    // capture the incoming item
    logic pick;    // choose a slot, start the id read
    logic step;    // find: move the scan to the next slot
    logic judge;   // final read cycle: settle the find outcome
    logic commit;  // update the table and load the result register
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic is_find;
    logic hit;
    logic last;
    logic out_free;
  } sts_t;

endpackage

[rtl/rrtt_ctrl.sv]
// Controller state machine: sequences accept, slot pick, id read and commit.
`timescale 1ns / 1ps
module rrtt_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_valid_i,
  input  rrtt_pkg::sts_t sts_i,
  output rrtt_pkg::ctl_t ctl_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_PICK   = 2'd1;
  localparam logic [1:0] S_READ   = 2'd2;
  localparam logic [1:0] S_COMMIT = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        ctl_o.ready = 1'b1;
        if (s_valid_i) begin
          ctl_o.load = 1'b1;
          state_d    = S_PICK;
        end
      end
      S_PICK: begin
        ctl_o.pick = 1'b1;
        state_d    = S_READ;
      end
      S_READ: begin
        // find walks the id store until a hit or the last slot
        if (sts_i.is_find && !sts_i.hit && !sts_i.last) begin
          ctl_o.step = 1'b1;
        end else begin
          ctl_o.judge = 1'b1;
          state_d     = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (sts_i.out_free) begin
          ctl_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[rtl/rrtt_dp.sv]
// Datapath: live flags, current task, id counter, id store and result register.
`timescale 1ns / 1ps
module rrtt_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rrtt_pkg::ctl_t                ctl_i,
  input  logic [rrtt_pkg::CMD_W-1:0]    cmd_i,
  input  logic [rrtt_pkg::RSLOT_W-1:0]  slot_i,
  input  logic [rrtt_pkg::ID_W-1:0]     task_id_i,
  input  logic                          m_ready_i,
  output logic                          m_valid_o,
  output logic                          status_o,
  output logic [rrtt_pkg::RSLOT_W-1:0]  result_slot_o,
  output logic [rrtt_pkg::ID_W-1:0]     result_id_o,
  output rrtt_pkg::sts_t                sts_o
);

  localparam int SW = rrtt_pkg::SLOT_W;
  localparam int IW = rrtt_pkg::ID_W;

  // latched command
  logic [rrtt_pkg::CMD_W-1:0]   cmd_q;
  logic [rrtt_pkg::RSLOT_W-1:0] slot_q;
  logic [IW-1:0]                want_q;

  // table state; a slot is running exactly when it is live and current
  logic [rrtt_pkg::SLOTS-1:0] live_q;
  logic                       cur_valid_q;
  logic [SW-1:0]              cur_slot_q;
  logic [IW-1:0]              cnt_q;

  logic [SW-1:0] idx_q;
  logic          ok_q;

  // id store, only meaningful for live slots
  logic [IW-1:0] id_mem [rrtt_pkg::SLOTS];
  logic [IW-1:0] rd_q;
  logic          rd_en;
  logic [SW-1:0] rd_addr;

  logic          out_valid_q;
  logic          status_q;
  logic [rrtt_pkg::RSLOT_W-1:0] rslot_q;
  logic [IW-1:0] rid_q;

  logic          slot_in_range;
  logic [SW-1:0] slot_idx;
  logic [SW-1:0] pick_idx;
  logic          pick_ok;
  logic [SW-1:0] free_idx;
  logic          free_found;
  logic [SW-1:0] next_idx;
  logic          next_found;
  logic [IW-1:0] cnt_next;
  logic [IW-1:0] res_id;

  assign slot_in_range = 32'(slot_q) < rrtt_pkg::SLOTS;
  assign slot_idx      = SW'(slot_q);
  assign cnt_next      = (cnt_q == rrtt_pkg::ID_MAX) ? IW'(1) : cnt_q + IW'(1);

  // lowest dead slot: descending loop leaves the lowest one standing
  always_comb begin
    free_idx   = '0;
    free_found = 1'b0;
    for (int i = rrtt_pkg::SLOTS - 1; i >= 0; i--) begin
      if (!live_q[i]) begin
        free_idx   = SW'(i);
        free_found = 1'b1;
      end
    end
  end

  // first live slot after the current one, wrapping
  always_comb begin
    logic [SW:0] sum;
    next_idx   = '0;
    next_found = 1'b0;
    for (int k = rrtt_pkg::SLOTS - 1; k >= 1; k--) begin
      sum = {1'b0, cur_slot_q} + (SW+1)'(k);
      if (sum >= (SW+1)'(rrtt_pkg::SLOTS)) begin
        sum = sum - (SW+1)'(rrtt_pkg::SLOTS);
      end
      if (live_q[sum[SW-1:0]]) begin
        next_idx   = sum[SW-1:0];
        next_found = 1'b1;
      end
    end
  end

  always_comb begin
    pick_idx = '0;
    pick_ok  = 1'b0;
    unique case (cmd_q)
      rrtt_pkg::CMD_CREATE: begin
        pick_idx = free_idx;
        pick_ok  = free_found;
      end
      rrtt_pkg::CMD_SCHEDULE: begin
        pick_idx = next_found ? next_idx : cur_slot_q;
        pick_ok  = cur_valid_q && (next_found || live_q[cur_slot_q]);
      end
      rrtt_pkg::CMD_EXIT: begin
        pick_idx = slot_idx;
        pick_ok  = slot_in_range;
      end
      rrtt_pkg::CMD_DISPATCH: begin
        pick_idx = slot_idx;
        pick_ok  = slot_in_range && live_q[slot_idx];
      end
      default: begin
        // find settles its outcome in the scan; other codes fail
        pick_idx = '0;
        pick_ok  = 1'b0;
      end
    endcase
  end

  assign rd_en   = ctl_i.pick || ctl_i.step;
  assign rd_addr = ctl_i.pick ? pick_idx : idx_q + SW'(1);

  assign sts_o.is_find  = (cmd_q == rrtt_pkg::CMD_FIND);
  assign sts_o.hit      = live_q[idx_q] && (rd_q == want_q) && (want_q != '0);
  assign sts_o.last     = (idx_q == SW'(rrtt_pkg::SLOTS - 1));
  assign sts_o.out_free = !out_valid_q || m_ready_i;

  // a dead slot reads as id zero
  assign res_id = (cmd_q == rrtt_pkg::CMD_CREATE) ? cnt_next
                : (live_q[idx_q] ? rd_q : '0);

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q  <= cmd_i;
      slot_q <= slot_i;
      want_q <= task_id_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.commit && ok_q && cmd_q == rrtt_pkg::CMD_CREATE) begin
      id_mem[idx_q] <= cnt_next;
    end
    if (rd_en) begin
      rd_q <= id_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q      <= '0;
      cur_valid_q <= 1'b0;
      cur_slot_q  <= '0;
      cnt_q       <= '0;
      idx_q       <= '0;
      ok_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctl_i.pick) begin
        idx_q <= pick_idx;
        ok_q  <= pick_ok;
      end
      if (ctl_i.step) begin
        idx_q <= idx_q + SW'(1);
      end
      if (ctl_i.judge && sts_o.is_find) begin
        ok_q <= sts_o.hit;
      end
      if (ctl_i.commit && ok_q) begin
        case (cmd_q) inside
          rrtt_pkg::CMD_CREATE: begin
            live_q[idx_q] <= 1'b1;
            cnt_q         <= cnt_next;
          end
          rrtt_pkg::CMD_SCHEDULE, rrtt_pkg::CMD_DISPATCH: begin
            cur_slot_q  <= idx_q;
            cur_valid_q <= 1'b1;
          end
          rrtt_pkg::CMD_EXIT: begin
            live_q[idx_q] <= 1'b0;
            if (cur_slot_q == idx_q) begin
              cur_valid_q <= 1'b0;
            end
          end
          default: ;
        endcase
      end
      if (ctl_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.commit) begin
      status_q <= !ok_q;
      rslot_q  <= ok_q ? rrtt_pkg::RSLOT_W'(idx_q) : '0;
      rid_q    <= ok_q ? res_id : '0;
    end
  end

  assign m_valid_o     = out_valid_q;
  assign status_o      = status_q;
  assign result_slot_o = rslot_q;
  assign result_id_o   = rid_q;

endmodule

[rtl/round_robin_task_table.sv]
// Round-robin task table: top level with stream ports and checks.
//
// A table of SLOTS task slots (8), each dead, ready or running, driven by one
// command per input item (create, schedule, exit, find, dispatch) and
// answering each with exactly one result item. Every command passes through
// accept, slot pick, id store read and commit before the next item can be
// accepted. Find is the exception in the read step: it walks the single-port
// id store one slot per cycle until a hit or the last slot. A finished result
// sits in an output register, so the next item is accepted while it waits to
// be taken; commit stalls only if the previous result is still there. No
// clearing pass after reset is needed: the id store is qualified by per-slot
// live flags.
`timescale 1ns / 1ps
`include "round_robin_task_table_assert.svh"
module round_robin_task_table (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // [33:3] task_id, [2:0] slot
  input  logic [rrtt_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  // [2:0] cmd
  input  logic [rrtt_pkg::CMD_W-1:0]         s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // [33:3] result_id, [2:0] result_slot
  output logic [rrtt_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o,
  // [0] status
  output logic                               m_axis_tuser_o
);

  rrtt_pkg::ctl_t ctl;
  rrtt_pkg::sts_t sts;

  logic [rrtt_pkg::RSLOT_W-1:0] result_slot;
  logic [rrtt_pkg::ID_W-1:0]    result_id;

  rrtt_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .sts_i     (sts),
    .ctl_o     (ctl)
  );

  rrtt_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .cmd_i         (s_axis_tuser_i),
    .slot_i        (s_axis_tdata_i[2:0]),
    .task_id_i     (s_axis_tdata_i[33:3]),
    .m_ready_i     (m_axis_tready_i),
    .m_valid_o     (m_axis_tvalid_o),
    .status_o      (m_axis_tuser_o),
    .result_slot_o (result_slot),
    .result_id_o   (result_id),
    .sts_o         (sts)
  );

  assign s_axis_tready_o = ctl.ready;
  assign m_axis_tdata_o  = {{(rrtt_pkg::OUT_DATA_W - rrtt_pkg::ID_W - rrtt_pkg::RSLOT_W){1'b0}},
                            result_id, result_slot};

  `RRTT_ASSERT_NEXT(a_accept_then_pick,
                    s_axis_tvalid_i && s_axis_tready_o,
                    ctl.pick && !s_axis_tready_o,
                    "accepted item not followed by slot pick")
  `RRTT_ASSERT_NEXT(a_commit_shows_result,
                    ctl.commit,
                    m_axis_tvalid_o,
                    "commit did not present a result")
  `RRTT_ASSERT_NOW(a_fail_is_zero,
                   m_axis_tvalid_o && m_axis_tuser_o,
                   m_axis_tdata_o == '0,
                   "failed result carries nonzero slot or id")

endmodule

[tb/tb.sv]
// Self-checking testbench for the round-robin task table.
`timescale 1ns / 1ps
module tb;
  import rrtt_pkg::*;

  localparam logic [CMD_W-1:0] CMD_RSVD5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;
  localparam int RANDOM_ITEMS = 1500;

  typedef enum logic [1:0] {SLOT_DEAD = 2'd0, SLOT_READY = 2'd1, SLOT_RUN = 2'd2} slot_state_e;

  typedef struct packed {
    logic            status;
    logic [2:0]      slot;
    logic [ID_W-1:0] id;
  } answer_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [2:0]       slot;
    logic [ID_W-1:0]  tid;
    logic             typed;  // answer typed into the table
    answer_t          ans;
  } cmd_item_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [CMD_W-1:0]      s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;

  round_robin_task_table dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // shadow of the task table
  slot_state_e     tab_state [SLOTS];
  logic [ID_W-1:0] tab_id    [SLOTS];
  logic            cur_valid;
  int              cur_slot;
  logic [ID_W-1:0] id_ctr;

  answer_t   answer_q [$];
  cmd_item_t dir_q    [$];
  int        errors = 0;
  int        burst_left = 0;

  function automatic void run_slot(int s);
    if (cur_valid && cur_slot != s && tab_state[cur_slot] == SLOT_RUN)
      tab_state[cur_slot] = SLOT_READY;
    tab_state[s] = SLOT_RUN;
    cur_slot     = s;
    cur_valid    = 1'b1;
  endfunction

  // Applies one command to the shadow table and returns its answer.
  function automatic answer_t next_answer(logic [CMD_W-1:0] c, logic [2:0] s,
                                          logic [ID_W-1:0] want);
    answer_t r;
    logic    found;
    int      idx;
    r     = '{1'b1, 3'd0, '0};
    found = 1'b0;
    case (c)
      CMD_CREATE: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!found && tab_state[i] == SLOT_DEAD) begin
            found        = 1'b1;
            id_ctr       = (id_ctr == ID_MAX) ? ID_W'(1) : id_ctr + 1'b1;
            tab_state[i] = SLOT_READY;
            tab_id[i]    = id_ctr;
            r            = '{1'b0, 3'(i), id_ctr};
          end
        end
      end
      CMD_SCHEDULE: begin
        if (cur_valid) begin
          for (int i = 1; i < SLOTS; i++) begin
            idx = (cur_slot + i) % SLOTS;
            if (!found && tab_state[idx] == SLOT_READY) begin
              found = 1'b1;
              run_slot(idx);
              r = '{1'b0, 3'(idx), tab_id[idx]};
            end
          end
          if (!found && tab_state[cur_slot] != SLOT_DEAD) begin
            tab_state[cur_slot] = SLOT_RUN;
            r = '{1'b0, 3'(cur_slot), tab_id[cur_slot]};
          end
        end
      end
      CMD_EXIT: begin
        r            = '{1'b0, s, tab_id[s]};
        tab_state[s] = SLOT_DEAD;
        tab_id[s]    = '0;
        if (cur_valid && cur_slot == int'(s)) cur_valid = 1'b0;
      end
      CMD_FIND: begin
        if (want != '0) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (!found && tab_id[i] == want && tab_state[i] != SLOT_DEAD) begin
              found = 1'b1;
              r     = '{1'b0, 3'(i), tab_id[i]};
            end
          end
        end
      end
      CMD_DISPATCH: begin
        if (tab_state[s] != SLOT_DEAD) begin
          run_slot(s);
          r = '{1'b0, s, tab_id[s]};
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int pick_live_slot();
    int q [$];
    for (int i = 0; i < SLOTS; i++)
      if (tab_state[i] != SLOT_DEAD) q.push_back(i);
    if (q.size() == 0) return -1;
    return q[$urandom_range(0, q.size() - 1)];
  endfunction

  function automatic void add_row(logic [CMD_W-1:0] c, logic [2:0] s, logic [ID_W-1:0] t,
                                  logic typed, logic st, logic [2:0] rs,
                                  logic [ID_W-1:0] rid);
    dir_q.push_back('{c, s, t, typed, '{st, rs, rid}});
  endfunction

  function automatic void note_mismatch(answer_t want, answer_t got);
    errors++;
    if (errors <= 10)
      $display("mismatch at %0t: expected status %0d slot %0d id %0d, got status %0d slot %0d id %0d",
               $realtime, want.status, want.slot, want.id, got.status, got.slot, got.id);
  endfunction

  // Offers one item, bursts and gaps handled up front; returns at the negedge after acceptance.
  task automatic send_item(cmd_item_t it);
    answer_t pred;
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_DATA_W - ID_W - 3){1'b0}}, it.tid, it.slot};
    s_tuser  <= it.cmd;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    pred = next_answer(it.cmd, it.slot, it.tid);
    answer_q.push_back(it.typed ? it.ans : pred);
    @(negedge clk_i);
  endtask

  // result checker
  always @(posedge clk_i) begin
    answer_t got;
    got = '{m_tuser, m_tdata[2:0], m_tdata[ID_W+2:3]};
    if (rst_ni && m_tvalid && m_tready) begin
      if (answer_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result at %0t: status %0d slot %0d id %0d",
                   $realtime, got.status, got.slot, got.id);
      end else begin
        if (got !== answer_q[0]) note_mismatch(answer_q[0], got);
        void'(answer_q.pop_front());
      end
    end
  end

  // receiver: stall patterns, with a long hold-off now and then
  initial begin
    int seg;
    int len;
    int mode;
    seg = 0;
    @(posedge rst_ni);
    forever begin
      seg++;
      if (seg == 4 || seg % 30 == 0) begin
        @(negedge clk_i);
        m_tready <= 1'b0;
        repeat (400) @(negedge clk_i);
      end else begin
        mode = $urandom_range(0, 3);
        len  = $urandom_range(10, 120);
        repeat (len) begin
          @(negedge clk_i);
          case (mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 1) == 1);
            2:       m_tready <= ($urandom_range(0, 4) == 0);
            default: m_tready <= ($urandom_range(0, 7) != 0);
          endcase
        end
      end
    end
  end

  initial begin
    #4_000_000;
    $display("round_robin_task_table verification failed");
    $finish;
  end

  initial begin
    cmd_item_t it;
    int        r;
    int        s;
    logic      filling;
    for (int i = 0; i < SLOTS; i++) begin
      tab_state[i] = SLOT_DEAD;
      tab_id[i]    = '0;
    end
    cur_valid = 1'b0;
    cur_slot  = 0;
    id_ctr    = '0;

    // directed rows: typed answers where obvious, predictor elsewhere
    add_row(CMD_SCHEDULE, 3'd0, '0,     1, 1'b1, 3'd0, '0);    // no current task
    add_row(CMD_FIND,     3'd0, '0,     1, 1'b1, 3'd0, '0);    // id 0 never matches
    add_row(CMD_DISPATCH, 3'd0, '0,     1, 1'b1, 3'd0, '0);    // dead slot
    add_row(CMD_EXIT,     3'd7, '0,     1, 1'b0, 3'd7, '0);    // exit of dead slot
    add_row(CMD_RSVD7,    3'd7, ID_MAX, 1, 1'b1, 3'd0, '0);
    add_row(CMD_RSVD5,    3'd0, '0,     1, 1'b1, 3'd0, '0);
    add_row(CMD_CREATE,   3'd0, '0,     1, 1'b0, 3'd0, 31'd1);
    add_row(CMD_CREATE,   3'd7, ID_MAX, 1, 1'b0, 3'd1, 31'd2);
    add_row(CMD_DISPATCH, 3'd1, '0,     0, 1'b0, 3'd0, '0);
    add_row(CMD_SCHEDULE, 3'd0, '0,     0, 1'b0, 3'd0, '0);    // wraps to slot 0
    add_row(CMD_EXIT,     3'd1, '0,     0, 1'b0, 3'd0, '0);
    add_row(CMD_SCHEDULE, 3'd0, '0,     0, 1'b0, 3'd0, '0);    // nothing else ready
    add_row(CMD_EXIT,     3'd0, '0,     0, 1'b0, 3'd0, '0);    // current exits
    add_row(CMD_SCHEDULE, 3'd0, '0,     1, 1'b1, 3'd0, '0);
    for (int i = 0; i < SLOTS; i++)
      add_row(CMD_CREATE, 3'(i), '0,    0, 1'b0, 3'd0, '0);
    add_row(CMD_CREATE,   3'd0, '0,     1, 1'b1, 3'd0, '0);    // table full
    add_row(CMD_FIND,     3'd0, ID_MAX, 1, 1'b1, 3'd0, '0);
    add_row(CMD_FIND,     3'd0, 31'd5,  0, 1'b0, 3'd0, '0);
    add_row(CMD_RSVD6,    3'd5, 31'd5,  1, 1'b1, 3'd0, '0);

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_q[i]) send_item(dir_q[i]);

    filling = 1'b0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(0, 99) == 0) filling = !filling;
      it.slot  = 3'($urandom_range(0, 7));
      it.tid   = ID_W'($urandom());
      it.typed = 1'b0;
      it.ans   = '0;
      r = $urandom_range(0, 99);
      if (r < (filling ? 35 : 12))      it.cmd = CMD_CREATE;
      else if (r < (filling ? 55 : 32)) it.cmd = CMD_SCHEDULE;
      else if (r < (filling ? 65 : 65)) it.cmd = CMD_EXIT;
      else if (r < 82)                  it.cmd = CMD_FIND;
      else if (r < 95)                  it.cmd = CMD_DISPATCH;
      else                              it.cmd = 3'($urandom_range(5, 7));
      if (it.cmd == CMD_EXIT || it.cmd == CMD_DISPATCH) begin
        s = pick_live_slot();
        if (s >= 0 && $urandom_range(0, 4) != 0) it.slot = 3'(s);
      end
      if (it.cmd == CMD_FIND) begin
        r = $urandom_range(0, 99);
        s = pick_live_slot();
        if (r < 60 && s >= 0)  it.tid = tab_id[s];
        else if (r < 75)       it.tid = ID_W'($urandom_range(1, int'(id_ctr) + 2));
        else if (r < 85)       it.tid = '0;
      end
      send_item(it);
    end
    s_tvalid <= 1'b0;

    while (answer_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (errors == 0 && answer_q.size() == 0) begin
      $display("round_robin_task_table verification clean");
    end else begin
      $display("round_robin_task_table verification failed");
    end
    $finish;
  end

endmodule

[round_robin_task_table.f]
+incdir+rtl
rtl/rrtt_pkg.sv
rtl/rrtt_ctrl.sv
rtl/rrtt_dp.sv
rtl/round_robin_task_table.sv
tb/tb.sv
